>>> sv/qph_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qph_pkg: shared types and constants
// Widths, state encoding and small helpers for the quadratic probe hash table.
// ----------------------------------------------------------------------------
package qph_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int KEY_BITS    = 16;
	localparam int SIZE_W      = 11;
	localparam int PROBE_W     = 11;
	localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int SUM_W       = ADDR_W + 1;
	localparam int CMP_W       = (SIZE_W > SUM_W) ? SIZE_W : SUM_W;
	localparam int WORD_W      = KEY_BITS + 1;
	localparam int KCNT_W      = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;

	localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(1024);
	localparam logic [SIZE_W-1:0] SIZE_MAX   = SIZE_W'(TABLE_DEPTH);

	// operation codes on the kind input
	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_SEARCH = 1'b1;

	typedef enum logic [4:0] {
		S_CLEAR = 5'b00001,
		S_IDLE  = 5'b00010,
		S_MOD   = 5'b00100,
		S_READ  = 5'b01000,
		S_CHECK = 5'b10000
	} state_t;

	// first step between probe 0 and probe 1: (3 + 5) mod m
	function automatic logic [ADDR_W-1:0] eight_mod(input logic [SIZE_W-1:0] m);
		logic [3:0] r;
		begin
			case (m) inside
				SIZE_W'(1), SIZE_W'(2), SIZE_W'(4), SIZE_W'(8): r = 4'd0;
				SIZE_W'(3), SIZE_W'(6): r = 4'd2;
				SIZE_W'(5): r = 4'd3;
				SIZE_W'(7): r = 4'd1;
				default: r = 4'd8;
			endcase
			eight_mod = ADDR_W'(r);
		end
	endfunction

	// growth of the step per probe: (2 * 5) mod m
	function automatic logic [ADDR_W-1:0] ten_mod(input logic [SIZE_W-1:0] m);
		logic [3:0] r;
		begin
			case (m) inside
				SIZE_W'(1), SIZE_W'(2), SIZE_W'(5), SIZE_W'(10): r = 4'd0;
				SIZE_W'(3), SIZE_W'(9): r = 4'd1;
				SIZE_W'(4), SIZE_W'(8): r = 4'd2;
				SIZE_W'(6): r = 4'd4;
				SIZE_W'(7): r = 4'd3;
				default: r = 4'd10;
			endcase
			ten_mod = ADDR_W'(r);
		end
	endfunction

endpackage

>>> sv/qph_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qph_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module qph_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> sv/qph_rem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qph_rem: bit-serial remainder unit
// Restoring reduction of key mod m, one key bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module qph_rem
	import qph_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  logic [KEY_BITS-1:0] key,
	input  logic [SIZE_W-1:0]   m,
	output logic                done,
	output logic [ADDR_W-1:0]   rem
);

	logic                run_q;
	logic                done_q;
	logic [KCNT_W-1:0]   cnt_q;
	logic [KEY_BITS-1:0] sh_q;
	logic [ADDR_W-1:0]   rem_q;
	logic [SUM_W-1:0]    trial;
	logic [ADDR_W-1:0]   rem_next;

	// shift in next key bit, subtract m once if it fits
	always_comb begin
		trial = {rem_q, sh_q[KEY_BITS-1]};
		if (CMP_W'(trial) >= CMP_W'(m)) begin
			rem_next = ADDR_W'(CMP_W'(trial) - CMP_W'(m));
		end else begin
			rem_next = trial[ADDR_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (load) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == KCNT_W'(KEY_BITS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			sh_q  <= key;
			rem_q <= '0;
		end else if (run_q) begin
			sh_q  <= {sh_q[KEY_BITS-2:0], 1'b0};
			rem_q <= rem_next;
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

>>> sv/qph_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qph_step: probe slot stepper
// Walks h(i) = key + 3i + 5i^2 mod m by second differences, all mod m.
// ----------------------------------------------------------------------------
module qph_step
	import qph_pkg::*;
(
	input  logic              clk,
	input  logic              load,
	input  logic              step,
	input  logic [ADDR_W-1:0] h_init,
	input  logic [SIZE_W-1:0] m,
	output logic [ADDR_W-1:0] h
);

	logic [ADDR_W-1:0] h_q;
	logic [ADDR_W-1:0] d_q;
	logic [ADDR_W-1:0] ten_q;
	logic [SUM_W-1:0]  h_sum;
	logic [SUM_W-1:0]  d_sum;
	logic [ADDR_W-1:0] h_next;
	logic [ADDR_W-1:0] d_next;

	// both operands are below m, so one conditional subtract wraps the sum
	always_comb begin
		h_sum = SUM_W'(h_q) + SUM_W'(d_q);
		d_sum = SUM_W'(d_q) + SUM_W'(ten_q);
		if (CMP_W'(h_sum) >= CMP_W'(m)) begin
			h_next = ADDR_W'(CMP_W'(h_sum) - CMP_W'(m));
		end else begin
			h_next = h_sum[ADDR_W-1:0];
		end
		if (CMP_W'(d_sum) >= CMP_W'(m)) begin
			d_next = ADDR_W'(CMP_W'(d_sum) - CMP_W'(m));
		end else begin
			d_next = d_sum[ADDR_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			h_q   <= h_init;
			d_q   <= eight_mod(m);
			ten_q <= ten_mod(m);
		end else if (step) begin
			h_q <= h_next;
			d_q <= d_next;
		end
	end

	assign h = h_q;

endmodule

>>> sv/quadratic_probe_hash_table_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadratic_probe_hash_table_top: open-addressing hash table, quadratic probe
// Inserts or looks up 16-bit keys; probe i visits (key + 3i + 5i^2) mod m.
// ----------------------------------------------------------------------------
// Usage:
//  - Command word: kind/key, taken on a clock edge with start high and busy
//    low. kind 0 inserts the key, kind 1 searches for it.
//  - Result word: found/stored/probes, shown for one cycle with done high.
//    There is no backpressure; the receiver must take it in that cycle.
//  - table_size is written on any edge with table_size_we high. It takes
//    effect at the next accepted command; 0 acts as 1, values above the
//    table depth act as the depth. Write it only while the table is idle.
//  - Sequence: the bit-serial key mod m unit reduces the key, the
//    remainder is handed to the stepper, then each probe is a RAM read
//    followed by a check. A new command may be accepted in the same cycle
//    done is high.
//  - Probes go one at a time through the single RAM read port; the next
//    slot is read only after the previous probe has been checked.
//  - Reset: after arst_n is released, a clearing pass writes every one of
//    the 1024 slots empty, one per cycle; busy stays high until the pass ends.
//    Table_size writes are still taken during the pass.
// ----------------------------------------------------------------------------
module quadratic_probe_hash_table_top
	import qph_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic                kind,
	input  logic [KEY_BITS-1:0] key,
	input  logic                table_size_we,
	input  logic [SIZE_W-1:0]   table_size,
	output logic                done,
	output logic                found,
	output logic                stored,
	output logic [PROBE_W-1:0]  probes
);

	state_t              state_q;
	logic [SIZE_W-1:0]   size_q;        // configured size as written
	logic [SIZE_W-1:0]   m_q;           // effective modulus of the running op
	logic [SIZE_W-1:0]   m_eff;
	logic                kind_q;
	logic [KEY_BITS-1:0] key_q;
	logic [ADDR_W-1:0]   clr_q;         // clearing pass address
	logic [SIZE_W-1:0]   cnt_q;         // probes completed so far
	logic [SIZE_W-1:0]   cnt_inc;
	logic                done_q;
	logic                found_q;
	logic                stored_q;
	logic [PROBE_W-1:0]  probes_q;

	logic                accept;
	logic                rem_done;
	logic [ADDR_W-1:0]   rem;
	logic [ADDR_W-1:0]   slot;
	logic                step_load;
	logic                step_adv;

	logic                ram_we;
	logic [ADDR_W-1:0]   ram_waddr;
	logic [WORD_W-1:0]   ram_wdata;
	logic [WORD_W-1:0]   ram_rdata;
	logic                slot_valid;
	logic                slot_hit;
	logic                last_probe;

	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q != S_IDLE);

	// clamp the configured size to 1..TABLE_DEPTH
	always_comb begin
		if (size_q == '0) begin
			m_eff = SIZE_W'(1);
		end else if (size_q > SIZE_MAX) begin
			m_eff = SIZE_MAX;
		end else begin
			m_eff = size_q;
		end
	end

	// slot word is {valid, key}; a slot reads empty until written after clear
	assign slot_valid = ram_rdata[KEY_BITS];
	assign slot_hit   = slot_valid && (ram_rdata[KEY_BITS-1:0] == key_q);
	assign cnt_inc    = cnt_q + 1'b1;
	assign last_probe = (cnt_inc == m_q);

	assign step_load = (state_q == S_MOD) && rem_done;
	assign step_adv  = (state_q == S_CHECK) && !last_probe &&
		((kind_q == KIND_INSERT) ? slot_valid : (slot_valid && !slot_hit));

	// write port: clearing pass, or the insert landing on an empty slot
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = slot;
		ram_wdata = {1'b1, key_q};
		if (state_q == S_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = '0;
		end else if ((state_q == S_CHECK) && (kind_q == KIND_INSERT) && !slot_valid) begin
			ram_we = 1'b1;
		end
	end

	qph_rem u_rem (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (accept),
		.key    (key),
		.m      (m_eff),
		.done   (rem_done),
		.rem    (rem)
	);

	qph_step u_step (
		.clk    (clk),
		.load   (step_load),
		.step   (step_adv),
		.h_init (rem),
		.m      (m_q),
		.h      (slot)
	);

	qph_ram #(
		.WIDTH (WORD_W),
		.DEPTH (TABLE_DEPTH)
	) u_slots (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (slot),
		.rdata (ram_rdata)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			size_q  <= SIZE_RESET;
			clr_q   <= '0;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (table_size_we) begin
				size_q <= table_size;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == ADDR_W'(TABLE_DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						state_q <= S_MOD;
					end
				end
				S_MOD: begin
					cnt_q <= '0;
					if (rem_done) begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (step_adv) begin
						cnt_q   <= cnt_inc;
						state_q <= S_READ;
					end else begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// operation operands and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= kind;
			key_q  <= key;
			m_q    <= m_eff;
		end
		if ((state_q == S_CHECK) && !step_adv) begin
			found_q  <= 1'b0;
			stored_q <= 1'b0;
			probes_q <= PROBE_W'(cnt_inc);
			if ((kind_q == KIND_INSERT) && !slot_valid) begin
				stored_q <= 1'b1;
			end else if ((kind_q == KIND_SEARCH) && slot_hit) begin
				found_q <= 1'b1;
			end else if ((kind_q == KIND_SEARCH) && !slot_valid) begin
				found_q <= 1'b0;
			end else begin
				// all m_q probes used without stopping
				probes_q <= PROBE_W'(m_q + 1'b1);
			end
		end
	end

	assign done   = done_q;
	assign found  = found_q;
	assign stored = stored_q;
	assign probes = probes_q;

	// ---------------------------------------------------------------- checks
	a_one_outcome: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(found && stored))
		else $error("found and stored both set");

	a_probes_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (probes != '0))
		else $error("result with zero probes");

	a_slot_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_READ) |-> (SIZE_W'(slot) < m_q))
		else $error("probe slot outside table size");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (busy && !done))
		else $error("accepted command did not hold busy");

endmodule
